// ----- src/rmts_pkg.sv -----
// Shared types and constants for the rate monotonic tick scheduler.
// Used by rmts_ctrl, rmts_datapath and the top level; no dependencies.
package rmts_pkg;

	localparam int PACKED_SLOTS = 8;
	localparam int IN_W         = 8;
	localparam int OUT_W        = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 64;

	localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXEC_BUDGETS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TASK_PERIODS = 2'd2;

	localparam logic [3:0]            TASK_COUNT_RST   = 4'd1;
	localparam logic [CFG_DATA_W-1:0] EXEC_BUDGETS_RST = 64'h0;
	localparam logic [CFG_DATA_W-1:0] TASK_PERIODS_RST = 64'h0101_0101_0101_0101;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RELOAD,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic reload;
		logic scan_clr;
		logic scan_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

// ----- src/rmts_ctrl.sv -----
// Sequencer for one scheduler tick: accept, optional reload, slot scan, commit.
// Depends on rmts_pkg; drives rmts_datapath through cmd_t, reads sts_t.
module rmts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          restart,
	input  rmts_pkg::sts_t sts,
	output rmts_pkg::cmd_t cmd
);

	rmts_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmts_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			rmts_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.scan_clr = 1'b1;
					state_nx     = restart ? rmts_pkg::ST_RELOAD : rmts_pkg::ST_SCAN;
				end
			end
			rmts_pkg::ST_RELOAD: begin
				cmd.reload = 1'b1;
				state_nx   = rmts_pkg::ST_SCAN;
			end
			rmts_pkg::ST_SCAN: begin
				if (sts.scan_done) begin
					state_nx = rmts_pkg::ST_COMMIT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			rmts_pkg::ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nx   = rmts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = rmts_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/rmts_datapath.sv -----
// Task state, configuration registers, priority scan and result register.
// Depends on rmts_pkg; controlled by rmts_ctrl through cmd_t/sts_t.
module rmts_datapath #(
	parameter int MAX_TASKS = 8,
	parameter int TIME_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rmts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rmts_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  rmts_pkg::cmd_t                      cmd,
	output rmts_pkg::sts_t                      sts,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rmts_pkg::OUT_W-1:0]          m_tdata
);

	localparam int IDX_W    = $clog2(MAX_TASKS);
	localparam int CNT_W    = $clog2(MAX_TASKS + 1);
	localparam int PER_W    = TIME_BITS + 1;
	localparam int SLOT_LIM = (MAX_TASKS < rmts_pkg::PACKED_SLOTS) ?
		MAX_TASKS : rmts_pkg::PACKED_SLOTS;

	logic [3:0]                        task_count_q;
	logic [rmts_pkg::CFG_DATA_W-1:0]   exec_budgets_q;
	logic [rmts_pkg::CFG_DATA_W-1:0]   task_periods_q;

	logic [TIME_BITS-1:0] budget_q [MAX_TASKS];
	logic [TIME_BITS-1:0] cd_q     [MAX_TASKS];
	logic [TIME_BITS-1:0] bud_fld  [MAX_TASKS];
	logic [TIME_BITS-1:0] per_fld  [MAX_TASKS];
	logic [PER_W-1:0]     per_len  [MAX_TASKS];
	logic [TIME_BITS-1:0] bud_nx   [MAX_TASKS];
	logic [TIME_BITS-1:0] cd_nx    [MAX_TASKS];
	logic [MAX_TASKS-1:0] rel;
	logic [7:0]           mask;

	logic [CNT_W-1:0]     active_n;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     slot;
	logic                 found_q;
	logic [IDX_W-1:0]     best_q;
	logic [PER_W-1:0]     best_per_q;

	logic                 out_valid_q;
	logic [3:0]           running_q;
	logic [7:0]           mask_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q   <= rmts_pkg::TASK_COUNT_RST;
			exec_budgets_q <= rmts_pkg::EXEC_BUDGETS_RST;
			task_periods_q <= rmts_pkg::TASK_PERIODS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rmts_pkg::REG_TASK_COUNT:   task_count_q   <= cfg_data[3:0];
				rmts_pkg::REG_EXEC_BUDGETS: exec_budgets_q <= cfg_data;
				rmts_pkg::REG_TASK_PERIODS: task_periods_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-slot fields; zero period means a full 2^TIME_BITS ticks
	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_fld
		if (g < rmts_pkg::PACKED_SLOTS) begin : g_packed
			assign bud_fld[g] = TIME_BITS'(exec_budgets_q[8*g +: 8]);
			assign per_fld[g] = TIME_BITS'(task_periods_q[8*g +: 8]);
		end else begin : g_unpacked
			assign bud_fld[g] = '0;
			assign per_fld[g] = '0;
		end
		assign per_len[g] = (per_fld[g] == '0) ? {1'b1, {TIME_BITS{1'b0}}} :
			{1'b0, per_fld[g]};
	end

	for (genvar b = 0; b < 8; b++) begin : g_mask
		if (b < MAX_TASKS) begin : g_on
			assign mask[b] = rel[b];
		end else begin : g_off
			assign mask[b] = 1'b0;
		end
	end

	always_comb begin
		if (int'(task_count_q) > SLOT_LIM) begin
			active_n = CNT_W'(SLOT_LIM);
		end else begin
			active_n = CNT_W'(task_count_q);
		end
	end

	assign slot          = cnt_q[IDX_W-1:0];
	assign sts.scan_done = (cnt_q == active_n);
	assign sts.out_free  = !out_valid_q || m_tready;

	// end-of-tick update: consume one unit, then advance countdowns
	always_comb begin
		for (int k = 0; k < MAX_TASKS; k++) begin
			bud_nx[k] = budget_q[k];
			cd_nx[k]  = cd_q[k];
			rel[k]    = 1'b0;
			if (found_q && best_q == IDX_W'(k)) begin
				bud_nx[k] = budget_q[k] - TIME_BITS'(1);
			end
			if (CNT_W'(k) < active_n) begin
				if (cd_q[k] == TIME_BITS'(1)) begin
					rel[k]    = 1'b1;
					bud_nx[k] = bud_fld[k];
					cd_nx[k]  = per_fld[k];
				end else begin
					cd_nx[k] = cd_q[k] - TIME_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_TASKS; k++) begin
				budget_q[k] <= '0;
				cd_q[k]     <= '0;
			end
		end else if (cmd.reload) begin
			for (int k = 0; k < MAX_TASKS; k++) begin
				budget_q[k] <= bud_fld[k];
				cd_q[k]     <= per_fld[k];
			end
		end else if (cmd.commit) begin
			for (int k = 0; k < MAX_TASKS; k++) begin
				budget_q[k] <= bud_nx[k];
				cd_q[k]     <= cd_nx[k];
			end
		end
	end

	// one slot per cycle; strict less-than keeps the lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (budget_q[slot] != '0 && (!found_q || per_len[slot] < best_per_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && budget_q[slot] != '0 &&
			(!found_q || per_len[slot] < best_per_q)) begin
			best_q     <= slot;
			best_per_q <= per_len[slot];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			running_q <= found_q ? (4'(best_q) + 4'd1) : 4'd0;
			mask_q    <= mask;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, mask_q, running_q};

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("result committed over an untaken result");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !sts.scan_done)
		else $error("scan stepped past the active slots");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_task_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> running_q <= 4'(SLOT_LIM))
		else $error("running task outside the active slots");

endmodule

// ----- src/rate_monotonic_tick_scheduler.sv -----
// Top level of the rate monotonic tick scheduler.
// Depends on rmts_pkg, rmts_ctrl and rmts_datapath.
//
//  channel | direction | payload (low bit first)
//  s_*     | in        | tdata[0] restart, rest zero
//  m_*     | out       | tdata[3:0] running_task, [11:4] release_mask, rest zero
//  cfg_*   | in        | cfg_index selects task_count/exec_budgets/task_periods
//
// A tick runs from transfer through an optional reload (on restart), the slot
// scan (one task slot per cycle) and the commit into the result register.
// s_tready is high only between ticks; a finished result waits in the output
// register while the next tick is taken in, and the commit stalls on m_tready.
// Reset clears task budgets and countdowns; registers return to their defaults.
module rate_monotonic_tick_scheduler #(
	parameter int MAX_TASKS = 8,
	parameter int TIME_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rmts_pkg::IN_W-1:0]         s_tdata,   // restart
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rmts_pkg::OUT_W-1:0]        m_tdata,   // running_task, release_mask
	input  logic                              cfg_we,
	input  logic [rmts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rmts_pkg::CFG_DATA_W-1:0]   cfg_data
);

	rmts_pkg::cmd_t cmd;
	rmts_pkg::sts_t sts;

	rmts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.restart  (s_tdata[0]),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmts_datapath #(
		.MAX_TASKS (MAX_TASKS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
